// File: design/boot_eeprom_record_parser_top_assert.svh
// ----------------------------------------------------------------------------
// boot_eeprom_record_parser_top_assert.svh
// Assertion macros used by the record parser checker.
// ----------------------------------------------------------------------------
`ifndef BOOT_EEPROM_RECORD_PARSER_TOP_ASSERT_SVH
`define BOOT_EEPROM_RECORD_PARSER_TOP_ASSERT_SVH

// Expression must hold at every clock edge out of reset.
`define BEP_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("bep assertion failed: always");

// Antecedent implies the consequent at the next clock edge.
`define BEP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bep assertion failed: next cycle");

`endif

// File: design/bep_pkg.sv
// ----------------------------------------------------------------------------
// bep_pkg
// Types and constants of the boot EEPROM record parser.
// ----------------------------------------------------------------------------
package bep_pkg;

   // record field phase
   typedef enum logic [2:0] {
      PH_LEN_HI  = 3'd0,
      PH_LEN_LO  = 3'd1,
      PH_ADDR_HI = 3'd2,
      PH_ADDR_LO = 3'd3,
      PH_DATA    = 3'd4,
      PH_CLOSED  = 3'd5
   } phase_type;

   localparam logic [7:0] MAGIC_BYTE   = 8'hC2;
   localparam logic [3:0] HEADER_BYTES = 4'd8;
   localparam logic [3:0] MIN_IMAGE    = 4'd13;

   localparam int ADDR_W  = 17;
   localparam int LEN_W   = 10;
   localparam int RSP_W   = 32;

   // one result transaction
   typedef struct packed {
      logic              write_strobe;
      logic [ADDR_W-1:0] write_addr;
      logic [7:0]        write_byte;
      logic              finished;
      logic              status;
   } result_type;

endpackage

// File: design/bep_core.sv
// ----------------------------------------------------------------------------
// bep_core
// Parser state and per-byte decode; state advances on step.
// ----------------------------------------------------------------------------
module bep_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           image_byte,
   input  logic                 is_final,
   output bep_pkg::result_type  result
);

   bep_pkg::phase_type               phase_ff, phase_in;
   logic [3:0]                       hdr_ff, hdr_in;
   logic [bep_pkg::LEN_W-1:0]        len_ff, len_in;
   logic [bep_pkg::ADDR_W-1:0]       rec_addr_ff, rec_addr_in;
   logic [bep_pkg::LEN_W-1:0]        left_ff, left_in;
   logic [3:0]                       seen_ff, seen_in;
   logic                             halted_ff, halted_in;
   logic                             bad_ff, bad_in;
   logic                             stream_open;
   logic [bep_pkg::LEN_W-1:0]        offset;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= bep_pkg::PH_LEN_HI;
         hdr_ff      <= '0;
         len_ff      <= '0;
         rec_addr_ff <= '0;
         left_ff     <= '0;
         seen_ff     <= '0;
         halted_ff   <= 1'b0;
         bad_ff      <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         hdr_ff      <= hdr_in;
         len_ff      <= len_in;
         rec_addr_ff <= rec_addr_in;
         left_ff     <= left_in;
         seen_ff     <= seen_in;
         halted_ff   <= halted_in;
         bad_ff      <= bad_in;
      end
   end

   // next state and result for the byte at hand
   always_comb begin
      phase_in    = phase_ff;
      hdr_in      = hdr_ff;
      len_in      = len_ff;
      rec_addr_in = rec_addr_ff;
      left_in     = left_ff;
      seen_in     = seen_ff;
      halted_in   = halted_ff;
      bad_in      = bad_ff;
      result      = '0;
      offset      = len_ff - left_ff;

      unique case (phase_ff) inside
         bep_pkg::PH_LEN_HI, bep_pkg::PH_LEN_LO, bep_pkg::PH_ADDR_HI,
         bep_pkg::PH_ADDR_LO, bep_pkg::PH_DATA: stream_open = 1'b1;
         default:                                stream_open = 1'b0;
      endcase

      if (stream_open) begin
         if (seen_ff < bep_pkg::MIN_IMAGE) begin
            seen_in = seen_ff + 4'd1;
         end

         if (!halted_ff) begin
            if (hdr_ff < bep_pkg::HEADER_BYTES) begin
               // header: check magic, skip the rest
               if (hdr_ff == 4'd0 && image_byte != bep_pkg::MAGIC_BYTE) begin
                  bad_in    = 1'b1;
                  halted_in = 1'b1;
               end
               hdr_in = hdr_ff + 4'd1;
            end else begin
               unique case (phase_ff)
                  bep_pkg::PH_LEN_HI: begin
                     // top bit marks the end record
                     if (image_byte[7]) begin
                        halted_in = 1'b1;
                     end else begin
                        len_in   = {image_byte[1:0], 8'h00};
                        phase_in = bep_pkg::PH_LEN_LO;
                     end
                  end
                  bep_pkg::PH_LEN_LO: begin
                     len_in   = len_ff | {2'b00, image_byte};
                     phase_in = bep_pkg::PH_ADDR_HI;
                  end
                  bep_pkg::PH_ADDR_HI: begin
                     rec_addr_in = {1'b0, image_byte, 8'h00};
                     phase_in    = bep_pkg::PH_ADDR_LO;
                  end
                  bep_pkg::PH_ADDR_LO: begin
                     rec_addr_in = {1'b0, rec_addr_ff[15:0] | {8'h00, image_byte}};
                     left_in     = len_ff;
                     phase_in    = (len_ff == '0) ? bep_pkg::PH_LEN_HI : bep_pkg::PH_DATA;
                  end
                  bep_pkg::PH_DATA: begin
                     result.write_strobe = 1'b1;
                     result.write_addr   = rec_addr_ff + {7'd0, offset};
                     result.write_byte   = image_byte;
                     left_in             = left_ff - 10'd1;
                     if (left_in == '0) begin
                        phase_in = bep_pkg::PH_LEN_HI;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // last byte closes the stream; short image is not initialised
         if (is_final) begin
            if (seen_in < bep_pkg::MIN_IMAGE) begin
               bad_in = 1'b1;
            end
            phase_in = bep_pkg::PH_CLOSED;
         end
      end

      result.finished = (phase_in == bep_pkg::PH_CLOSED) || halted_in;
      result.status   = bad_in;
   end

endmodule

// File: design/boot_eeprom_record_parser_top.sv
// Path: an accepted req transaction is held in the input register, and its
// result is then registered in the result register, which drives rsp_tvalid.
// Throughput: one byte per cycle; the input register and the result register
// each hold while the stage after them is stalled.
// Reset: synchronous, active high; clears both valid flags and all parser
// state, so the next byte is taken as the first header byte.
// ----------------------------------------------------------------------------
// boot_eeprom_record_parser_top
// Boot EEPROM image parser: one result per image byte, a memory write for each record data byte.
// ----------------------------------------------------------------------------
module boot_eeprom_record_parser_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,  // [7:0] image_byte
   input  logic                      req_tlast,  // is_final
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [16:0] write_addr, [24:17] write_byte, [25] finished, [26] status
   output logic [bep_pkg::RSP_W-1:0] rsp_tdata,
   output logic                      rsp_tuser   // write_strobe
);

   logic                 s1_valid_ff, s1_valid_in;
   logic [7:0]           s1_byte_ff;
   logic                 s1_final_ff;
   logic                 out_valid_ff, out_valid_in;
   bep_pkg::result_type  out_ff;
   bep_pkg::result_type  core_result;
   logic                 req_accept;
   logic                 out_free;
   logic                 s1_move;

   // pipeline handshake
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff  <= req_tdata;
         s1_final_ff <= req_tlast;
      end
   end

   bep_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (s1_move),
      .image_byte (s1_byte_ff),
      .is_final   (s1_final_ff),
      .result     (core_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.write_strobe;
   assign rsp_tdata  = {5'd0, out_ff.status, out_ff.finished,
                        out_ff.write_byte, out_ff.write_addr};

endmodule

// File: design/bep_checker.sv
// ----------------------------------------------------------------------------
// bep_checker
// Port-level checks on the result channel of the record parser.
// ----------------------------------------------------------------------------
`include "boot_eeprom_record_parser_top_assert.svh"

module bep_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [bep_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      rsp_tuser
);

   // stalled transaction holds its payload
   `BEP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // no write means zero address and byte
   `BEP_ASSERT_ALWAYS(a_idle_zero, clock, reset, !(rsp_tvalid && !rsp_tuser) || (rsp_tdata[24:0] == 25'd0))

   // a write never comes from an image marked not initialised
   `BEP_ASSERT_ALWAYS(a_write_ok, clock, reset, !(rsp_tvalid && rsp_tuser) || !rsp_tdata[26])

   // write address stays within record address plus the longest offset
   `BEP_ASSERT_ALWAYS(a_addr_range, clock, reset, !(rsp_tvalid && rsp_tuser) || (rsp_tdata[16:0] <= 17'd66557))

endmodule

bind boot_eeprom_record_parser_top bep_checker u_bep_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
